@@ sv/cursor_window_hit_focus_defines.svh @@
// Assertion macros for the cursor / window hit-test block.
// Taken in by the files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef CURSOR_WINDOW_HIT_FOCUS_DEFINES_SVH
`define CURSOR_WINDOW_HIT_FOCUS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CWHF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CWHF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/cwhf_pkg.sv @@
// Shared types, constants and helpers for the cursor / window hit-test block.
// No dependencies.
package cwhf_pkg;

    localparam int SLOT_IN_W     = 6;
    localparam int COORD_W       = 16;
    localparam int ID_W          = 32;
    localparam int CUR_W         = 12;
    localparam int SCREEN_W      = 13;
    localparam int BUTTON_W      = 8;
    localparam int DEF_SLOTS     = 64;
    localparam int SCREEN_MAX    = 4096;
    localparam int RST_SCREEN_W  = 1024;
    localparam int RST_SCREEN_H  = 768;

    // Register indexes of the configuration port
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // Request codes
    localparam logic REQ_TABLE_WRITE = 1'b0;
    localparam logic REQ_MOUSE       = 1'b1;

    // One window slot as kept in the table memory
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic [ID_W-1:0]    owner;
        logic [ID_W-1:0]    ident;
    } win_entry_t;

    // Screen register as the clamp sees it: zero acts as one, above max acts as max
    function automatic logic [SCREEN_W-1:0] eff_size(input logic [SCREEN_W-1:0] r);
        logic [SCREEN_W-1:0] res;
        res = r;
        if (r == '0)
            res = SCREEN_W'(1);
        else if (r > SCREEN_W'(SCREEN_MAX))
            res = SCREEN_W'(SCREEN_MAX);
        return res;
    endfunction

    // Add a signed delta and clamp into [0, lim-1]
    function automatic logic [CUR_W-1:0] move_clamp(input logic [CUR_W-1:0]   pos,
                                                    input logic [COORD_W-1:0] delta,
                                                    input logic [SCREEN_W-1:0] lim);
        logic signed [COORD_W+1:0] p;
        logic signed [COORD_W+1:0] lim_s;
        logic [CUR_W-1:0]          res;
        p     = $signed({{(COORD_W+2-CUR_W){1'b0}}, pos})
              + $signed({{2{delta[COORD_W-1]}}, delta});
        lim_s = $signed({{(COORD_W+2-SCREEN_W){1'b0}}, lim});
        if (p < 0)
            res = '0;
        else if (p >= lim_s)
            res = CUR_W'(lim - SCREEN_W'(1));
        else
            res = p[CUR_W-1:0];
        return res;
    endfunction

endpackage

@@ sv/cwhf_table.sv @@
// Window table: slot memory with registered read, plus per-slot valid flops.
// Depends on cwhf_pkg for the slot entry type and the default depth.
module cwhf_table
    import cwhf_pkg::*;
#(
    parameter int WINDOW_SLOTS = DEF_SLOTS,
    parameter int IDX_W        = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  win_entry_t       wr_entry,
    input  logic             wr_visible,
    input  logic [IDX_W-1:0] rd_addr,
    output win_entry_t       rd_entry,
    output logic             rd_valid
);

    win_entry_t               mem [WINDOW_SLOTS];
    logic [WINDOW_SLOTS-1:0]  valid_reg;
    win_entry_t               rd_entry_reg;
    logic                     rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    // Clearing a slot is an ordinary write: the fields are stored too and the valid bit drops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= wr_visible;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

@@ sv/cursor_window_hit_focus.sv @@
// Cursor tracking, topmost-window hit test and click-to-focus.
// A table-write word goes from acceptance straight to the finish state. A mouse word clamps the cursor on
// acceptance, then scans the window table from the top slot down, one memory read per
// slot, stopping at the first hit, so a hit in a high slot ends the scan early. One word is
// in flight at a time; the input is stalled from acceptance until its result is loaded
// into the output register.
module cursor_window_hit_focus
    import cwhf_pkg::*;
#(
    parameter int WINDOW_SLOTS = DEF_SLOTS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [SCREEN_W-1:0]  cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 req_type,
    input  logic [SLOT_IN_W-1:0] slot,
    input  logic signed [COORD_W-1:0] win_x,
    input  logic signed [COORD_W-1:0] win_y,
    input  logic [COORD_W-1:0]   win_width,
    input  logic [COORD_W-1:0]   win_height,
    input  logic [ID_W-1:0]      win_owner,
    input  logic [ID_W-1:0]      win_ident,
    input  logic                 win_visible,
    input  logic signed [COORD_W-1:0] delta_x,
    input  logic signed [COORD_W-1:0] delta_y,
    input  logic [BUTTON_W-1:0]  buttons,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CUR_W-1:0]     cursor_x,
    output logic [CUR_W-1:0]     cursor_y,
    output logic [ID_W-1:0]      hover_owner,
    output logic [ID_W-1:0]      focus_owner,
    output logic [ID_W-1:0]      focus_window,
    output logic                 focus_changed
);

    `include "cursor_window_hit_focus_defines.svh"

    localparam int IDX_W  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int SLW_W  = IDX_W + SLOT_IN_W;
    localparam int WIDE_W = COORD_W + 2;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [SCREEN_W-1:0] scr_w_reg, scr_h_reg;
    logic [CUR_W-1:0]    cur_x_reg, cur_x_next;
    logic [CUR_W-1:0]    cur_y_reg, cur_y_next;
    logic [CUR_W-1:0]    out_cx_reg, out_cx_next;
    logic [CUR_W-1:0]    out_cy_reg, out_cy_next;
    logic [ID_W-1:0]     hov_reg, hov_next;
    logic [ID_W-1:0]     foc_owner_reg, foc_owner_next;
    logic [ID_W-1:0]     foc_win_reg, foc_win_next;
    logic                is_mouse_reg, is_mouse_next;
    logic                click_reg, click_next;
    logic [IDX_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                issue_live_reg, issue_live_next;
    logic                chk_pend_reg, chk_pend_next;
    logic                hit_reg, hit_next;
    logic [ID_W-1:0]     hit_owner_reg, hit_owner_next;
    logic [ID_W-1:0]     hit_ident_reg, hit_ident_next;
    logic                out_valid_reg, out_valid_next;
    logic                changed_reg, changed_next;

    logic                in_accept;
    logic                out_load;
    logic [SLW_W-1:0]    slot_wide;
    logic                tbl_wr_en;
    win_entry_t          tbl_wr_entry;
    win_entry_t          rd_entry;
    logic                rd_valid;
    logic                hit_now;
    logic signed [WIDE_W-1:0] cx_s, cy_s, wx_s, wy_s, wx_end, wy_end;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    // Slot numbers at or above the table depth are dropped
    assign slot_wide = SLW_W'(slot);
    assign tbl_wr_en = in_accept && (req_type == REQ_TABLE_WRITE)
                       && (slot_wide < SLW_W'(WINDOW_SLOTS));

    always_comb
    begin
        tbl_wr_entry.x     = win_x;
        tbl_wr_entry.y     = win_y;
        tbl_wr_entry.w     = win_width;
        tbl_wr_entry.h     = win_height;
        tbl_wr_entry.owner = win_owner;
        tbl_wr_entry.ident = win_ident;
    end

    cwhf_table #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .IDX_W        (IDX_W)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (tbl_wr_en),
        .wr_addr    (slot_wide[IDX_W-1:0]),
        .wr_entry   (tbl_wr_entry),
        .wr_visible (win_visible),
        .rd_addr    (scan_idx_reg),
        .rd_entry   (rd_entry),
        .rd_valid   (rd_valid)
    );

    // Half-open containment test on the slot read last cycle
    always_comb
    begin
        cx_s    = $signed({{(WIDE_W-CUR_W){1'b0}}, cur_x_reg});
        cy_s    = $signed({{(WIDE_W-CUR_W){1'b0}}, cur_y_reg});
        wx_s    = $signed({{2{rd_entry.x[COORD_W-1]}}, rd_entry.x});
        wy_s    = $signed({{2{rd_entry.y[COORD_W-1]}}, rd_entry.y});
        wx_end  = wx_s + $signed({2'b00, rd_entry.w});
        wy_end  = wy_s + $signed({2'b00, rd_entry.h});
        hit_now = rd_valid && (cx_s >= wx_s) && (cx_s < wx_end)
                  && (cy_s >= wy_s) && (cy_s < wy_end);
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        out_cx_next     = out_cx_reg;
        out_cy_next     = out_cy_reg;
        hov_next        = hov_reg;
        foc_owner_next  = foc_owner_reg;
        foc_win_next    = foc_win_reg;
        is_mouse_next   = is_mouse_reg;
        click_next      = click_reg;
        scan_idx_next   = scan_idx_reg;
        issue_live_next = issue_live_reg;
        chk_pend_next   = 1'b0;
        hit_next        = hit_reg;
        hit_owner_next  = hit_owner_reg;
        hit_ident_next  = hit_ident_reg;
        changed_next    = changed_reg;
        out_valid_next  = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    is_mouse_next = (req_type == REQ_MOUSE);
                    click_next    = buttons[0];
                    hit_next      = 1'b0;
                    if (req_type == REQ_MOUSE)
                    begin
                        cur_x_next      = move_clamp(cur_x_reg, delta_x, eff_size(scr_w_reg));
                        cur_y_next      = move_clamp(cur_y_reg, delta_y, eff_size(scr_h_reg));
                        scan_idx_next   = IDX_W'(WINDOW_SLOTS - 1);
                        issue_live_next = 1'b1;
                        state_next      = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                // Issue the next read down while checking the one in flight
                if (issue_live_reg)
                begin
                    chk_pend_next = 1'b1;
                    if (scan_idx_reg == '0)
                        issue_live_next = 1'b0;
                    else
                        scan_idx_next = scan_idx_reg - IDX_W'(1);
                end
                if (chk_pend_reg && hit_now)
                begin
                    hit_next        = 1'b1;
                    hit_owner_next  = rd_entry.owner;
                    hit_ident_next  = rd_entry.ident;
                    issue_live_next = 1'b0;
                    chk_pend_next   = 1'b0;
                    state_next      = ST_FINISH;
                end
                else if (chk_pend_reg && !issue_live_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    changed_next   = 1'b0;
                    out_valid_next = 1'b1;
                    out_cx_next    = cur_x_reg;
                    out_cy_next    = cur_y_reg;
                    if (is_mouse_reg)
                    begin
                        hov_next = hit_reg ? hit_owner_reg : '0;
                        if (hit_reg && click_reg && (foc_owner_reg != hit_owner_reg))
                        begin
                            foc_owner_next = hit_owner_reg;
                            foc_win_next   = hit_ident_reg;
                            changed_next   = 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scr_w_reg      <= SCREEN_W'(RST_SCREEN_W);
            scr_h_reg      <= SCREEN_W'(RST_SCREEN_H);
            cur_x_reg      <= CUR_W'(RST_SCREEN_W / 2);
            cur_y_reg      <= CUR_W'(RST_SCREEN_H / 2);
            out_cx_reg     <= CUR_W'(RST_SCREEN_W / 2);
            out_cy_reg     <= CUR_W'(RST_SCREEN_H / 2);
            hov_reg        <= '0;
            foc_owner_reg  <= '0;
            foc_win_reg    <= '0;
            is_mouse_reg   <= 1'b0;
            click_reg      <= 1'b0;
            scan_idx_reg   <= '0;
            issue_live_reg <= 1'b0;
            chk_pend_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            changed_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            out_cx_reg     <= out_cx_next;
            out_cy_reg     <= out_cy_next;
            hov_reg        <= hov_next;
            foc_owner_reg  <= foc_owner_next;
            foc_win_reg    <= foc_win_next;
            is_mouse_reg   <= is_mouse_next;
            click_reg      <= click_next;
            scan_idx_reg   <= scan_idx_next;
            issue_live_reg <= issue_live_next;
            chk_pend_reg   <= chk_pend_next;
            hit_reg        <= hit_next;
            out_valid_reg  <= out_valid_next;
            changed_reg    <= changed_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_SCREEN_WIDTH:  scr_w_reg <= cfg_wdata;
                    REG_SCREEN_HEIGHT: scr_h_reg <= cfg_wdata;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_owner_reg <= hit_owner_next;
        hit_ident_reg <= hit_ident_next;
    end

    // Output registers hold the word while stalled; the cursor copy keeps the next
    // word's clamp from showing through
    assign out_valid     = out_valid_reg;
    assign cursor_x      = out_cx_reg;
    assign cursor_y      = out_cy_reg;
    assign hover_owner   = hov_reg;
    assign focus_owner   = foc_owner_reg;
    assign focus_window  = foc_win_reg;
    assign focus_changed = changed_reg;

    `CWHF_ASSERT_NOW(a_focus_move_on_hover, out_valid_reg && changed_reg,
        foc_owner_reg == hov_reg, "focus moved to an owner other than the hovered one")
    `CWHF_ASSERT_NEXT(a_write_skips_scan, in_accept && (req_type == REQ_TABLE_WRITE),
        state_reg == ST_FINISH, "table write did not go straight to finish")
    `CWHF_ASSERT_NOW(a_hit_from_scan, $rose(hit_reg),
        $past(state_reg) == ST_SCAN, "hit flag set outside the scan")
    `CWHF_ASSERT_NOW(a_check_only_in_scan, chk_pend_reg,
        state_reg == ST_SCAN, "pending table check outside the scan")

endmodule

@@ tb/cursor_window_hit_focus_test.sv @@
// Self-checking bench for cursor_window_hit_focus: cursor clamp, topmost-window hit test
// and click-to-focus, checked word by word against an in-bench predictor.
// Depends on cwhf_pkg and the cursor_window_hit_focus RTL only.
`timescale 1ns / 1ps

module cursor_window_hit_focus_test;
    import cwhf_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = DEF_SLOTS + 8;

    typedef struct {
        logic                      req;
        logic [SLOT_IN_W-1:0]      slot;
        logic signed [COORD_W-1:0] wx;
        logic signed [COORD_W-1:0] wy;
        logic [COORD_W-1:0]        ww;
        logic [COORD_W-1:0]        wh;
        logic [ID_W-1:0]           owner;
        logic [ID_W-1:0]           ident;
        logic                      vis;
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
        logic [BUTTON_W-1:0]       btn;
    } ui_word_t;

    typedef struct {
        logic [CUR_W-1:0] col;
        logic [CUR_W-1:0] row;
        logic [ID_W-1:0]  hover;
        logic [ID_W-1:0]  fpid;
        logic [ID_W-1:0]  fbuf;
        logic             moved;
    } hit_result_t;

    typedef struct {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [COORD_W-1:0]        wid;
        logic [COORD_W-1:0]        hgt;
        logic [ID_W-1:0]           owner;
        logic [ID_W-1:0]           ident;
        logic                      live;
    } win_rect_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic                      cfg_index;
    logic [SCREEN_W-1:0]       cfg_wdata;
    logic                      in_valid;
    logic                      in_stall;
    logic                      req_type;
    logic [SLOT_IN_W-1:0]      slot;
    logic signed [COORD_W-1:0] win_x;
    logic signed [COORD_W-1:0] win_y;
    logic [COORD_W-1:0]        win_width;
    logic [COORD_W-1:0]        win_height;
    logic [ID_W-1:0]           win_owner;
    logic [ID_W-1:0]           win_ident;
    logic                      win_visible;
    logic signed [COORD_W-1:0] delta_x;
    logic signed [COORD_W-1:0] delta_y;
    logic [BUTTON_W-1:0]       buttons;
    logic                      out_valid;
    logic                      out_stall;
    logic [CUR_W-1:0]          cursor_x;
    logic [CUR_W-1:0]          cursor_y;
    logic [ID_W-1:0]           hover_owner;
    logic [ID_W-1:0]           focus_owner;
    logic [ID_W-1:0]           focus_window;
    logic                      focus_changed;

    // predictor state
    logic [SCREEN_W-1:0] scr_w;
    logic [SCREEN_W-1:0] scr_h;
    logic [CUR_W-1:0]    cursor_col;
    logic [CUR_W-1:0]    cursor_row;
    logic [ID_W-1:0]     hover_id;
    logic [ID_W-1:0]     focus_pid;
    logic [ID_W-1:0]     focus_buf;
    win_rect_t           win_tbl [DEF_SLOTS];

    hit_result_t pending_hits [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          hold_left = 0;

    cursor_window_hit_focus dut (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: a long hold-off when requested, random stalls otherwise.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic int screen_span(input logic [SCREEN_W-1:0] r);
        if (r == '0)
            return 1;
        if (r > SCREEN_MAX)
            return SCREEN_MAX;
        return int'(r);
    endfunction

    function automatic logic [CUR_W-1:0] step_cursor(input logic [CUR_W-1:0] pos,
                                                     input logic signed [COORD_W-1:0] d,
                                                     input logic [SCREEN_W-1:0] r);
        int p;
        int span;
        span = screen_span(r);
        p = int'(pos) + int'(d);
        if (p < 0)
            p = 0;
        if (p >= span)
            p = span - 1;
        return CUR_W'(p);
    endfunction

    task automatic predict_hit_focus(input ui_word_t wd, output hit_result_t r);
        int hit;
        int cx;
        int cy;
        hit = -1;
        r.moved = 1'b0;
        if (wd.req == REQ_TABLE_WRITE)
        begin
            win_tbl[wd.slot] = '{left: wd.wx, top: wd.wy, wid: wd.ww, hgt: wd.wh,
                                 owner: wd.owner, ident: wd.ident, live: wd.vis};
        end
        else
        begin
            cursor_col = step_cursor(cursor_col, wd.dx, scr_w);
            cursor_row = step_cursor(cursor_row, wd.dy, scr_h);
            cx = int'(cursor_col);
            cy = int'(cursor_row);
            // top slot wins; bounds are half-open
            for (int i = DEF_SLOTS - 1; i >= 0; i--)
            begin
                if (hit < 0 && win_tbl[i].live
                    && cx >= int'(win_tbl[i].left)
                    && cx < int'(win_tbl[i].left) + int'(win_tbl[i].wid)
                    && cy >= int'(win_tbl[i].top)
                    && cy < int'(win_tbl[i].top) + int'(win_tbl[i].hgt))
                    hit = i;
            end
            if (hit < 0)
            begin
                hover_id = '0;
            end
            else
            begin
                hover_id = win_tbl[hit].owner;
                if (wd.btn[0] && focus_pid != win_tbl[hit].owner)
                begin
                    focus_pid = win_tbl[hit].owner;
                    focus_buf = win_tbl[hit].ident;
                    r.moved = 1'b1;
                end
            end
        end
        r.col   = cursor_col;
        r.row   = cursor_row;
        r.hover = hover_id;
        r.fpid  = focus_pid;
        r.fbuf  = focus_buf;
    endtask

    // Offer one word; the expectation is booked as soon as valid goes up.
    task automatic send_word(input ui_word_t wd);
        hit_result_t r;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        predict_hit_focus(wd, r);
        pending_hits.push_back(r);
        req_type    <= wd.req;
        slot        <= wd.slot;
        win_x       <= wd.wx;
        win_y       <= wd.wy;
        win_width   <= wd.ww;
        win_height  <= wd.wh;
        win_owner   <= wd.owner;
        win_ident   <= wd.ident;
        win_visible <= wd.vis;
        delta_x     <= wd.dx;
        delta_y     <= wd.dy;
        buttons     <= wd.btn;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_screen(input int wval, input int hval);
        settle_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SCREEN_WIDTH;
        cfg_wdata <= SCREEN_W'(wval);
        @(posedge clk);
        cfg_index <= REG_SCREEN_HEIGHT;
        cfg_wdata <= SCREEN_W'(hval);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        scr_w = SCREEN_W'(wval);
        scr_h = SCREEN_W'(hval);
    endtask

    function automatic ui_word_t table_word(input int s, input int x, input int y,
                                            input int w, input int h,
                                            input logic [ID_W-1:0] owner,
                                            input logic [ID_W-1:0] ident,
                                            input logic vis);
        ui_word_t wd;
        wd = '{default: '0};
        wd.req   = REQ_TABLE_WRITE;
        wd.slot  = SLOT_IN_W'(s);
        wd.wx    = COORD_W'(x);
        wd.wy    = COORD_W'(y);
        wd.ww    = COORD_W'(w);
        wd.wh    = COORD_W'(h);
        wd.owner = owner;
        wd.ident = ident;
        wd.vis   = vis;
        return wd;
    endfunction

    function automatic ui_word_t mouse_word(input int dx, input int dy,
                                            input logic [BUTTON_W-1:0] btn);
        ui_word_t wd;
        wd = '{default: '0};
        wd.req = REQ_MOUSE;
        wd.dx  = COORD_W'(dx);
        wd.dy  = COORD_W'(dy);
        wd.btn = btn;
        return wd;
    endfunction

    function automatic ui_word_t random_word();
        ui_word_t wd;
        int sx;
        int sy;
        int mx;
        int my;
        sx = screen_span(scr_w);
        sy = screen_span(scr_h);
        mx = sx / 8 + 4;
        my = sy / 8 + 4;
        wd.req   = ($urandom_range(99) < 30) ? REQ_TABLE_WRITE : REQ_MOUSE;
        wd.slot  = SLOT_IN_W'($urandom);
        wd.wx    = COORD_W'($urandom);
        wd.wy    = COORD_W'($urandom);
        wd.ww    = COORD_W'($urandom);
        wd.wh    = COORD_W'($urandom);
        wd.owner = $urandom;
        wd.ident = $urandom;
        wd.vis   = 1'($urandom);
        wd.dx    = COORD_W'($urandom);
        wd.dy    = COORD_W'($urandom);
        wd.btn   = BUTTON_W'($urandom);
        // mostly on-screen windows in a few stacked slots, small owner pool,
        // short moves; the rest keeps full-range noise
        if ($urandom_range(9) != 0)
        begin
            wd.slot  = SLOT_IN_W'($urandom_range(1) ? $urandom_range(7)
                                                    : $urandom_range(63, 56));
            wd.wx    = COORD_W'(int'($urandom_range(sx + 63)) - 64);
            wd.wy    = COORD_W'(int'($urandom_range(sy + 63)) - 64);
            wd.ww    = COORD_W'($urandom_range(sx / 2 + 8));
            wd.wh    = COORD_W'($urandom_range(sy / 2 + 8));
            wd.owner = $urandom_range(6);
            wd.vis   = ($urandom_range(99) < 85);
            wd.dx    = COORD_W'(int'($urandom_range(2 * mx)) - mx);
            wd.dy    = COORD_W'(int'($urandom_range(2 * my)) - my);
        end
        return wd;
    endfunction

    always @(posedge clk)
    begin : result_check
        hit_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_hits.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending, cursor (%0d,%0d)",
                                          cursor_x, cursor_y));
            end
            else
            begin
                want = pending_hits.pop_front();
                if (cursor_x !== want.col)
                    report_mismatch($sformatf("cursor_x %0d, want %0d", cursor_x, want.col));
                if (cursor_y !== want.row)
                    report_mismatch($sformatf("cursor_y %0d, want %0d", cursor_y, want.row));
                if (hover_owner !== want.hover)
                    report_mismatch($sformatf("hover_owner %h, want %h",
                                              hover_owner, want.hover));
                if (focus_owner !== want.fpid)
                    report_mismatch($sformatf("focus_owner %h, want %h",
                                              focus_owner, want.fpid));
                if (focus_window !== want.fbuf)
                    report_mismatch($sformatf("focus_window %h, want %h",
                                              focus_window, want.fbuf));
                if (focus_changed !== want.moved)
                    report_mismatch($sformatf("focus_changed %b, want %b",
                                              focus_changed, want.moved));
            end
        end
    end

    task automatic test_directed_cases();
        tx_idle_pct = 0;
        rx_idle_pct = 30;
        send_word(mouse_word(0, 0, 8'h00));
        send_word(mouse_word(0, 0, 8'h01));                 // click on desktop
        send_word(table_word(0, 0, 0, 1024, 768, 32'd10, 32'd100, 1'b1));
        send_word(table_word(63, 500, 380, 20, 10, 32'd20, 32'd200, 1'b1));
        send_word(mouse_word(0, 0, 8'h01));                 // focus to top window
        send_word(mouse_word(0, 0, 8'h01));                 // same owner again
        send_word(mouse_word(7, 5, 8'hFE));                 // last pixel inside, no click
        send_word(mouse_word(1, 1, 8'hFF));                 // just outside, falls to slot 0
        send_word(table_word(63, 500, 380, 20, 10, 32'd20, 32'd200, 1'b0));
        send_word(mouse_word(-8, -6, 8'h01));
        send_word(table_word(40, 0, 0, 0, 0, 32'd30, 32'd300, 1'b1));
        send_word(table_word(41, 0, 0, 2000, 0, 32'd31, 32'd301, 1'b1));
        send_word(mouse_word(-512, -384, 8'h01));           // zero-sized windows never hit
        send_word(table_word(62, -32768, -32768, 65535, 65535,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_word(mouse_word(32767, 32767, 8'h01));
        send_word(mouse_word(-32768, -32768, 8'h01));
        send_word(table_word(62, 32767, 32767, 65535, 65535, 32'd5, 32'd55, 1'b1));
        send_word(mouse_word(0, 0, 8'h01));
    endtask

    task automatic test_screen_limits();
        set_screen(0, 8191);                                // act as 1 and 4096
        send_word(table_word(3, 0, 0, 1, 1, 32'd7, 32'd77, 1'b1));  // cursor not reclamped yet
        send_word(mouse_word(100, 5000, 8'h01));
        set_screen(4096, 1);
        send_word(mouse_word(32767, 0, 8'h01));
        set_screen(8191, 0);
        send_word(mouse_word(-32768, 5, 8'h01));
        set_screen(4097, 4096);
        send_word(mouse_word(32767, 32767, 8'h00));
    endtask

    task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct,
                                       input int wval, input int hval);
        set_screen(wval, hval);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) send_word(random_word());
    endtask

    // Hold the output off long enough that the block backs up into its input.
    task automatic test_output_backpressure();
        settle_idle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left = 300;
        repeat (24) send_word(random_word());
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= REG_SCREEN_WIDTH;
        cfg_wdata   <= '0;
        in_valid    <= 1'b0;
        out_stall   <= 1'b0;
        req_type    <= REQ_TABLE_WRITE;
        slot        <= '0;
        win_x       <= '0;
        win_y       <= '0;
        win_width   <= '0;
        win_height  <= '0;
        win_owner   <= '0;
        win_ident   <= '0;
        win_visible <= 1'b0;
        delta_x     <= '0;
        delta_y     <= '0;
        buttons     <= '0;

        scr_w      = SCREEN_W'(RST_SCREEN_W);
        scr_h      = SCREEN_W'(RST_SCREEN_H);
        cursor_col = CUR_W'(RST_SCREEN_W / 2);
        cursor_row = CUR_W'(RST_SCREEN_H / 2);
        hover_id   = '0;
        focus_pid  = '0;
        focus_buf  = '0;
        foreach (win_tbl[i])
            win_tbl[i] = '{default: '0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_screen_limits();
        test_random_traffic(560, 14, 62, 1024, 768);
        test_random_traffic(560, 62, 14, 4096, 2000);
        test_output_backpressure();
        test_random_traffic(560, 0, 0, 640, 480);

        settle_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
